[rtl/lsg_pkg.sv]
// Package for the line segment geometry unit: setup states, CORDIC table, rounding helpers.
package lsg_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CS_N         = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    localparam logic signed [31:0] PI_Q28     = 32'sd843314857;
    localparam logic [15:0]        PI_Q13     = 16'd25736;
    localparam logic signed [47:0] NORM_LIMIT = 48'sd1099511627776;

    localparam logic [2:0] REG_START_X = 3'd0;
    localparam logic [2:0] REG_START_Y = 3'd1;
    localparam logic [2:0] REG_END_X   = 3'd2;
    localparam logic [2:0] REG_END_Y   = 3'd3;
    localparam logic [2:0] REG_REVERSE = 3'd4;

    typedef enum logic [3:0] {
        ST_START,
        ST_SQX,
        ST_SQY,
        ST_SQRT,
        ST_DIVX,
        ST_DIVY,
        ST_NORM,
        ST_CORDIC,
        ST_FIN,
        ST_DONE
    } t_setup_state;

    function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0:    v = 32'sd210828714;
            5'd1:    v = 32'sd124459457;
            5'd2:    v = 32'sd65760959;
            5'd3:    v = 32'sd33381290;
            5'd4:    v = 32'sd16755422;
            5'd5:    v = 32'sd8385879;
            5'd6:    v = 32'sd4193963;
            5'd7:    v = 32'sd2097109;
            5'd8:    v = 32'sd1048571;
            5'd9:    v = 32'sd524287;
            5'd10:   v = 32'sd262144;
            5'd11:   v = 32'sd131072;
            5'd12:   v = 32'sd65536;
            5'd13:   v = 32'sd32768;
            5'd14:   v = 32'sd16384;
            5'd15:   v = 32'sd8192;
            5'd16:   v = 32'sd4096;
            5'd17:   v = 32'sd2048;
            5'd18:   v = 32'sd1024;
            5'd19:   v = 32'sd512;
            5'd20:   v = 32'sd256;
            5'd21:   v = 32'sd128;
            5'd22:   v = 32'sd64;
            5'd23:   v = 32'sd32;
            5'd24:   v = 32'sd16;
            5'd25:   v = 32'sd8;
            5'd26:   v = 32'sd4;
            5'd27:   v = 32'sd2;
            5'd28:   v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // round v / 2^30, half away from zero
    function automatic logic signed [36:0] rnd30(input logic signed [65:0] v);
        logic [65:0] mag;
        logic [65:0] q;
        mag = v[65] ? 66'(-v) : 66'(v);
        q   = (mag + 66'd536870912) >> 30;
        return v[65] ? 37'(-$signed(q[36:0])) : $signed(q[36:0]);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [31:0] r;
        if (v > 38'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -38'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/line_segment_geometry_unit.sv]
// Line segment geometry unit: setup engine for segment constants and a three stage item pipeline.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------------
//  query   | in        | i_valid / o_ready      | travel_distance, query_x, query_y
//  result  | out       | o_valid / i_ready      | pos_x, pos_y, projection, heading, length, degen
//  config  | in        | i_cfg_we (no wait)     | i_cfg_index, i_cfg_data
//
// One transaction per cycle while o_ready is high; stages subtract, multiply, round/add/saturate.
// Each config write (and reset) starts a setup pass: squares, 32-step square root, two 63-step
// restoring divisions, up to 40 normalising doublings and CORDIC_STEPS CORDIC iterations;
// o_ready stays low while it runs; a zero-length segment goes from ST_START straight to ST_FIN.
// A stall at the result side holds all pipeline stages; nothing is dropped or repeated.
module line_segment_geometry_unit
    import lsg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_travel_distance,
    input  logic signed [31:0] i_query_x,
    input  logic signed [31:0] i_query_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_projection,
    output logic signed [15:0] o_heading,
    output logic [30:0]        o_segment_length,
    output logic               o_degenerate
);

    // configuration
    logic signed [31:0] r_sx, r_sy, r_ex, r_ey;
    logic               r_rev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx  <= '0;
            r_sy  <= '0;
            r_ex  <= '0;
            r_ey  <= '0;
            r_rev <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START_X: r_sx  <= i_cfg_data;
                REG_START_Y: r_sy  <= i_cfg_data;
                REG_END_X:   r_ex  <= i_cfg_data;
                REG_END_Y:   r_ey  <= i_cfg_data;
                REG_REVERSE: r_rev <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // setup engine
    t_setup_state r_state, n_state;
    logic signed [31:0] r_dxh, r_dyh;
    logic               r_k, r_deg;
    logic [63:0]        r_ssq, r_root;
    logic [31:0]        r_lr;
    logic [62:0]        r_num;
    logic [31:0]        r_rem;
    logic [30:0]        r_q;
    logic [5:0]         r_cnt;
    logic signed [31:0] r_ux, r_uy;
    logic signed [47:0] r_cx, r_cy;
    logic signed [31:0] r_z;
    logic signed [15:0] r_head;
    logic [30:0]        r_len;
    logic               setup_busy;

    logic signed [32:0] dx, dy;
    logic               big;
    logic               deg_now;
    logic signed [47:0] cx0, cy0;
    logic [31:0]        ax, ay;
    logic [63:0]        sq_bit, sq_try;
    logic               sq_take;
    logic [63:0]        root_next;
    logic [32:0]        div_try;
    logic               div_ge;
    logic [62:0]        num_x, num_y;
    logic signed [47:0] shx, shy;
    logic [31:0]        zmag, zq;
    logic [32:0]        len_full;

    always_comb begin
        dx  = 33'(r_ex) - 33'(r_sx);
        dy  = 33'(r_ey) - 33'(r_sy);
        big = (dx >= 33'sh080000000) || (dx <= -33'sh080000000)
           || (dy >= 33'sh080000000) || (dy <= -33'sh080000000);
        deg_now = (dx == 33'sd0) && (dy == 33'sd0);
        cx0 = r_rev ? -48'(dx) : 48'(dx);
        cy0 = r_rev ? -48'(dy) : 48'(dy);
        ax  = r_dxh[31] ? 32'(-r_dxh) : 32'(r_dxh);
        ay  = r_dyh[31] ? 32'(-r_dyh) : 32'(r_dyh);
        sq_bit    = 64'd1 << {r_cnt[4:0], 1'b0};
        sq_try    = r_root + sq_bit;
        sq_take   = r_ssq >= sq_try;
        root_next = sq_take ? (r_root >> 1) + sq_bit : r_root >> 1;
        div_try = {r_rem, r_num[62]};
        div_ge  = div_try >= {1'b0, r_lr};
        // dividend |d| * 2^30 + floor(L / 2) gives the rounded quotient
        num_x   = 63'({ax, 30'd0}) + 63'(r_lr >> 1);
        num_y   = 63'({ay, 30'd0}) + 63'(r_lr >> 1);
        shx     = r_cx >>> r_cnt[4:0];
        shy     = r_cy >>> r_cnt[4:0];
        zmag    = r_z[31] ? 32'(-r_z) : 32'(r_z);
        zq      = (zmag + 32'd16384) >> 15;
        len_full = {r_root[31:0], 1'b0} >> !r_k;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_START:  n_state = deg_now ? ST_FIN : ST_SQX;
            ST_SQX:    n_state = ST_SQY;
            ST_SQY:    n_state = ST_SQRT;
            ST_SQRT:   if (r_cnt == 6'd0) n_state = ST_DIVX;
            ST_DIVX:   if (r_cnt == 6'd0) n_state = ST_DIVY;
            ST_DIVY:   if (r_cnt == 6'd0) n_state = ST_NORM;
            ST_NORM:   if (!(r_cx < NORM_LIMIT && r_cy < NORM_LIMIT && r_cy > -NORM_LIMIT))
                           n_state = ST_CORDIC;
            ST_CORDIC: if (r_cnt == 6'(CS_N - 1)) n_state = ST_FIN;
            ST_FIN:    n_state = ST_DONE;
            ST_DONE:   n_state = ST_DONE;
            default:   n_state = ST_START;
        endcase
        if (i_cfg_we) n_state = ST_START;
    end

    // outputs of the sequencer
    always_comb begin
        setup_busy = (r_state != ST_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_START: begin
                r_deg <= deg_now;
                r_k   <= big;
                r_dxh <= big ? 32'(dx >>> 1) : dx[31:0];
                r_dyh <= big ? 32'(dy >>> 1) : dy[31:0];
                if (cx0 < 0) begin
                    r_z  <= (cy0 >= 0) ? PI_Q28 : -PI_Q28;
                    r_cx <= -cx0;
                    r_cy <= -cy0;
                end else begin
                    r_z  <= '0;
                    r_cx <= cx0;
                    r_cy <= cy0;
                end
            end
            ST_SQX: r_ssq <= ax * ax;
            ST_SQY: begin
                r_ssq  <= r_ssq + ay * ay;
                r_root <= '0;
                r_cnt  <= 6'd31;
            end
            ST_SQRT: begin
                if (sq_take) begin
                    r_ssq <= r_ssq - sq_try;
                end
                r_root <= root_next;
                r_cnt  <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_lr  <= root_next[31:0];
                    r_cnt <= 6'd62;
                    r_rem <= '0;
                    // dividend for the first division is loaded as the root finishes
                    r_num <= 63'({ax, 30'd0}) + 63'(root_next[32:1]);
                    r_q   <= '0;
                end
            end
            ST_DIVX, ST_DIVY: begin
                r_rem <= div_ge ? 32'(div_try - {1'b0, r_lr}) : div_try[31:0];
                r_q   <= {r_q[29:0], div_ge};
                r_num <= {r_num[61:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    if (r_state == ST_DIVX) begin
                        r_ux  <= r_dxh[31] ? -$signed({1'b0, r_q[29:0], div_ge})
                                           : $signed({1'b0, r_q[29:0], div_ge});
                        r_num <= num_y;
                        r_cnt <= 6'd62;
                        r_rem <= '0;
                        r_q   <= '0;
                    end else begin
                        r_uy  <= r_dyh[31] ? -$signed({1'b0, r_q[29:0], div_ge})
                                           : $signed({1'b0, r_q[29:0], div_ge});
                        r_cnt <= '0;
                    end
                end
            end
            ST_NORM: begin
                if (r_cx < NORM_LIMIT && r_cy < NORM_LIMIT && r_cy > -NORM_LIMIT) begin
                    r_cx <= r_cx <<< 1;
                    r_cy <= r_cy <<< 1;
                end
                r_cnt <= '0;
            end
            ST_CORDIC: begin
                if (!r_cy[47]) begin
                    r_cx <= r_cx + shy;
                    r_cy <= r_cy - shx;
                    r_z  <= r_z + atan_q28(r_cnt[4:0]);
                end else begin
                    r_cx <= r_cx - shy;
                    r_cy <= r_cy + shx;
                    r_z  <= r_z - atan_q28(r_cnt[4:0]);
                end
                r_cnt <= r_cnt + 6'd1;
            end
            ST_FIN: begin
                if (zq > {16'd0, PI_Q13}) begin
                    r_head <= r_z[31] ? -$signed(PI_Q13) : $signed(PI_Q13);
                end else begin
                    r_head <= r_z[31] ? -$signed(zq[15:0]) : $signed(zq[15:0]);
                end
                r_len <= len_full[32:31] != 2'd0 ? 31'h7fffffff : len_full[30:0];
            end
            default: ;
        endcase
    end

    // item pipeline
    logic r_v1, r_v2, r_v3;
    logic adv;
    logic signed [31:0] r1_d;
    logic signed [32:0] r1_qx, r1_qy;
    logic signed [63:0] r2_pdx, r2_pdy;
    logic signed [64:0] r2_ppx, r2_ppy;
    logic signed [31:0] r3_px, r3_py, r3_pr;
    logic signed [65:0] proj_sum;

    assign adv     = !r_v3 || i_ready;
    assign o_ready = !setup_busy && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid && o_ready;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign proj_sum = 66'(r2_ppx) + 66'(r2_ppy);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_d   <= i_travel_distance;
            r1_qx  <= 33'(i_query_x) - 33'(r_sx);
            r1_qy  <= 33'(i_query_y) - 33'(r_sy);
            r2_pdx <= r_ux * r1_d;
            r2_pdy <= r_uy * r1_d;
            r2_ppx <= 65'(r_ux) * 65'(r1_qx);
            r2_ppy <= 65'(r_uy) * 65'(r1_qy);
            r3_px  <= sat32(38'(r_sx) + 38'(rnd30(66'(r2_pdx))));
            r3_py  <= sat32(38'(r_sy) + 38'(rnd30(66'(r2_pdy))));
            r3_pr  <= sat32(38'(rnd30(proj_sum)));
        end
    end

    assign o_valid          = r_v3;
    assign o_pos_x          = r_deg ? 32'sd0 : r3_px;
    assign o_pos_y          = r_deg ? 32'sd0 : r3_py;
    assign o_projection     = r_deg ? 32'sd0 : r3_pr;
    assign o_heading        = r_deg ? 16'sd0 : r_head;
    assign o_segment_length = r_deg ? 31'd0 : r_len;
    assign o_degenerate     = r_deg;

endmodule

[tb/tb_line_segment_geometry_unit.sv]
// Testbench for the line segment geometry unit: directed and random queries checked against a predictor.
module tb_line_segment_geometry_unit;
    import lsg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] projection;
        logic signed [15:0] heading;
        logic [30:0]        seg_len;
        logic               degen;
    } t_geom;

    localparam longint ATAN_TBL[32] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
        2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic signed [31:0] i_travel_distance;
    logic signed [31:0] i_query_x;
    logic signed [31:0] i_query_y;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_pos_x;
    logic signed [31:0] o_pos_y;
    logic signed [31:0] o_projection;
    logic signed [15:0] o_heading;
    logic [30:0]        o_segment_length;
    logic               o_degenerate;

    line_segment_geometry_unit dut (.*);

    // segment as currently programmed
    longint seg_sx, seg_sy, seg_ex, seg_ey;
    bit     seg_rev;

    t_geom  pending_geom[$];
    int     err_count;
    int     cycle_count;
    bit     no_gaps;
    int     hold_len;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_line_segment_geometry_unit: errors");
            $finish;
        end
    end

    function automatic longint round_div(longint num, longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = num < 0 ? 64'(-num) : 64'(num);
        q = (mag + den / 2) / den;
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [15:0] vector_angle(longint x, longint y);
        longint z, nx, ny;
        longint lim;
        z = 0;
        lim = NORM_LIMIT;
        if (x < 0) begin
            z = (y >= 0) ? longint'(PI_Q28) : -longint'(PI_Q28);
            x = -x;
            y = -y;
        end
        while (x < lim && abs64(y) < lim) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < CS_N; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = z + ATAN_TBL[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = z - ATAN_TBL[i];
            end
            x = nx;
            y = ny;
        end
        z = round_div(z, 32768);
        if (z > 25736) z = 25736;
        if (z < -25736) z = -25736;
        return 16'(z);
    endfunction

    function automatic t_geom predict_geom(longint d, longint qx, longint qy);
        t_geom g;
        longint dx, dy, ux, uy, len;
        longint unsigned ssq, root;
        int k;
        dx = seg_ex - seg_sx;
        dy = seg_ey - seg_sy;
        qx = qx - seg_sx;
        qy = qy - seg_sy;
        k = 0;
        if (dx == 0 && dy == 0) begin
            g = '{0, 0, 0, 0, 0, 1'b1};
            return g;
        end
        g.heading = seg_rev ? vector_angle(-dx, -dy) : vector_angle(dx, dy);
        if (abs64(dx) >= 64'sd2147483648 || abs64(dy) >= 64'sd2147483648) begin
            dx = dx >>> 1;
            dy = dy >>> 1;
            k = 1;
        end
        ssq = 64'(abs64(dx) * abs64(dx)) + 64'(abs64(dy) * abs64(dy));
        root = int_sqrt(ssq);
        len = longint'(root << k);
        if (len > 64'sd2147483647) len = 64'sd2147483647;
        ux = round_div(dx * 64'sd1073741824, root);
        uy = round_div(dy * 64'sd1073741824, root);
        g.pos_x = 32'(clamp32(seg_sx + round_div(ux * d, 64'd1073741824)));
        g.pos_y = 32'(clamp32(seg_sy + round_div(uy * d, 64'd1073741824)));
        g.projection = 32'(clamp32(round_div(ux * qx + uy * qy, 64'd1073741824)));
        g.seg_len = 31'(len);
        g.degen = 1'b0;
        return g;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        err_count++;
    endtask

    // register write; returns at the edge that ends the write
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_START_X: seg_sx = longint'(signed'(data));
            REG_START_Y: seg_sy = longint'(signed'(data));
            REG_END_X:   seg_ex = longint'(signed'(data));
            REG_END_Y:   seg_ey = longint'(signed'(data));
            REG_REVERSE: seg_rev = data[0];
            default: ;
        endcase
    endtask

    task automatic set_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                               logic [31:0] ey, bit rev);
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        write_reg(REG_END_X, ex);
        write_reg(REG_END_Y, ey);
        write_reg(REG_REVERSE, {31'd0, rev});
    endtask

    task automatic send_query(logic [31:0] d, logic [31:0] qx, logic [31:0] qy);
        int gap;
        bit hit;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_travel_distance <= d;
        i_query_x         <= qx;
        i_query_y         <= qy;
        do begin
            @(negedge i_clk);
            hit = o_ready;
            @(posedge i_clk);
        end while (!hit);
        pending_geom.push_back(predict_geom(longint'(signed'(d)), longint'(signed'(qx)),
                                            longint'(signed'(qy))));
    endtask

    // drop valid and let the pipeline empty before touching registers
    task automatic drain;
        i_valid <= 1'b0;
        wait (pending_geom.size() == 0);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 65536)) - 32768) << 8;
        endcase
    endfunction

    // result side: random stalls, one long hold when asked
    initial begin
        int gap;
        bit hit;
        t_geom got, want;
        i_ready = 1'b0;
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 7);
            if (hold_len > 0) begin
                gap = hold_len;
                hold_len = 0;
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do begin
                @(negedge i_clk);
                hit = o_valid;
                got = '{o_pos_x, o_pos_y, o_projection, o_heading, o_segment_length,
                        o_degenerate};
                @(posedge i_clk);
            end while (!hit);
            if (pending_geom.size() == 0) begin
                report_mismatch("unexpected transaction", 1, 0);
            end else begin
                want = pending_geom.pop_front();
                if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
                if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
                if (got.projection !== want.projection)
                    report_mismatch("projection", got.projection, want.projection);
                if (got.heading !== want.heading)
                    report_mismatch("heading", got.heading, want.heading);
                if (got.seg_len !== want.seg_len)
                    report_mismatch("segment_length", got.seg_len, want.seg_len);
                if (got.degen !== want.degen)
                    report_mismatch("degenerate", got.degen, want.degen);
            end
        end
    end

    task automatic test_degenerate;
        send_query(32'h7fffffff, 32'h80000000, 32'h12345678);
        send_query(32'h0, 32'h0, 32'h0);
        drain();
        set_segment(32'h00050000, 32'hfffd0000, 32'h00050000, 32'hfffd0000, 1'b1);
        send_query(32'h00010000, 32'h7fffffff, 32'h7fffffff);
        drain();
    endtask

    task automatic test_field_extremes;
        set_segment(32'h0, 32'h0, 32'h00030000, 32'h00040000, 1'b0);
        send_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_query(32'h80000000, 32'h80000000, 32'h80000000);
        send_query(32'hffffffff, 32'h00000001, 32'hffffffff);
        send_query(32'h00050000, 32'h00030000, 32'h00040000);
        drain();
    endtask

    task automatic test_headings;
        // exactly backwards along x, a reversed forward segment, then down y and a reversed segment up y
        set_segment(32'h00100000, 32'h0, 32'hfff00000, 32'h0, 1'b0);
        send_query(32'h00020000, 32'h0, 32'h00010000);
        drain();
        set_segment(32'h0, 32'h00010000, 32'h00070000, 32'h00010000, 1'b1);
        send_query(32'h00020000, 32'hffff0000, 32'h0);
        drain();
        set_segment(32'h0, 32'h0, 32'h0, 32'hfff00000, 1'b0);
        send_query(32'h00020000, 32'h0, 32'h00010000);
        drain();
        set_segment(32'h0, 32'h0, 32'h0, 32'h00100000, 1'b1);
        send_query(32'hfffe0000, 32'h00010000, 32'h0);
        drain();
    endtask

    task automatic test_wide_segment;
        // span past 2^31 with length saturation, then saturating positions
        set_segment(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b0);
        send_query(32'h7fffffff, 32'h7fffffff, 32'h80000000);
        send_query(32'h80000000, 32'h0, 32'h0);
        drain();
        set_segment(32'h7fff0000, 32'h80010000, 32'h7fff8000, 32'h80008000, 1'b1);
        send_query(32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_query(32'h80000000, 32'h7fffffff, 32'h80000000);
        drain();
    endtask

    task automatic test_register_quirks;
        write_reg(3'd5, 32'h7fffffff);
        write_reg(3'd6, 32'h80000000);
        write_reg(3'd7, 32'hffffffff);
        write_reg(REG_REVERSE, 32'hfffffffe);
        send_query(32'h00010000, 32'h00020000, 32'h00030000);
        drain();
        write_reg(REG_REVERSE, 32'hffffffff);
        send_query(32'h00010000, 32'h00020000, 32'h00030000);
        drain();
    endtask

    task automatic test_backpressure;
        set_segment(32'h00010000, 32'h00020000, 32'hfff30000, 32'h00090000, 1'b0);
        no_gaps = 1'b1;
        hold_len = 300;
        repeat (40) send_query($urandom, $urandom, $urandom);
        no_gaps = 1'b0;
        drain();
    endtask

    task automatic test_random;
        int n;
        for (int ph = 0; ph < 12; ph++) begin
            set_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                        $urandom_range(0, 1));
            if ($urandom_range(0, 5) == 0) write_reg(REG_END_X, 32'(seg_sx));
            if ($urandom_range(0, 5) == 0) write_reg(REG_END_Y, 32'(seg_sy));
            no_gaps = (ph % 4 == 1);
            n = 100;
            repeat (n) begin
                if ($urandom_range(0, 3) == 0)
                    send_query(rand_coord(), rand_coord(), rand_coord());
                else
                    send_query($urandom, $urandom, $urandom);
            end
            no_gaps = 1'b0;
            drain();
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        i_valid           = 1'b0;
        i_travel_distance = '0;
        i_query_x         = '0;
        i_query_y         = '0;
        seg_sx = 0;
        seg_sy = 0;
        seg_ex = 0;
        seg_ey = 0;
        seg_rev = 1'b0;
        err_count = 0;
        cycle_count = 0;
        no_gaps = 1'b0;
        hold_len = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_degenerate();
        test_field_extremes();
        test_headings();
        test_wide_segment();
        test_register_quirks();
        test_backpressure();
        test_random();

        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_line_segment_geometry_unit: clean");
        end else begin
            $display("tb_line_segment_geometry_unit: errors");
        end
        $finish;
    end

endmodule
